>>> rtl/ihrs_pkg.sv
// Package for the indexed histogram running stats unit.
// Holds command/status structs, placement codes and register addresses; no dependencies.
`default_nettype none
package ihrs_pkg;
  localparam logic [1:0] PLACE_BIN   = 2'd0;
  localparam logic [1:0] PLACE_BELOW = 2'd1;
  localparam logic [1:0] PLACE_ABOVE = 2'd2;

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd4;

  typedef struct packed {
    logic load;      // capture input item, start bin divide
    logic bin_done;  // bin quotient ready: read stores
    logic mean_go;   // start mean divide
    logic finish;    // compute and write back, present result
  } ihrs_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic clear_done;
  } ihrs_sts_t;
endpackage
`default_nettype wire

>>> rtl/ihrs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ihrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] addr,
  input  wire [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> rtl/ihrs_div.sv
// Radix-2 restoring divider for unsigned 64/64 operands, one bit per cycle.
// No dependencies.
`default_nettype none
module ihrs_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [63:0] dividend,
  input  wire  [63:0] divisor,
  output logic [63:0] quotient,
  output logic        busy,
  output logic        done
);
  logic [63:0] rem;
  logic [63:0] dvd;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem, dvd[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], dvd[63]};
          dvd <= {dvd[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = dvd;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) !(start && busy))
    else $error("divider restarted while busy");
endmodule
`default_nettype wire

>>> rtl/ihrs_ctrl.sv
// Controller state machine for the histogram running stats unit.
// Depends on ihrs_pkg.
`default_nettype none
module ihrs_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_fire,
  input  wire                 out_taken,
  input  ihrs_pkg::ihrs_sts_t sts,
  output ihrs_pkg::ihrs_cmd_t cmd,
  output logic                in_ready,
  output logic                out_valid,
  output logic                clearing
);
  import ihrs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BDIV  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MDIV  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_ADDR  = 3'd6;
  localparam logic [2:0] S_FETCH = 3'd7;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic        out_full;

  assign clearing = (state == S_CLEAR);
  assign in_ready = (state == S_IDLE) && (!out_full || out_taken);
  assign out_valid = out_full;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_BDIV;
        end
      end
      S_BDIV: begin
        if (sts.div_done) begin
          cmd.bin_done = 1'b1;
          state_next = S_ADDR;
        end
      end
      S_ADDR:  state_next = S_FETCH;
      S_FETCH: state_next = S_READ;
      S_READ: begin
        cmd.mean_go = 1'b1;
        state_next = S_MDIV;
      end
      S_MDIV: if (sts.div_done) state_next = S_FIN;
      S_FIN: begin
        if (!out_full || out_taken) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_full <= 1'b1;
      end else if (out_taken) begin
        out_full <= 1'b0;
      end
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst) in_fire |-> state == S_IDLE)
    else $error("item taken while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish && out_full && !out_taken))
    else $error("result overwritten");
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !(sts.div_busy && state == S_IDLE))
    else $error("divider busy in idle");
endmodule
`default_nettype wire

>>> rtl/ihrs_dp.sv
// Datapath: per-channel stores, bin and mean arithmetic, shared divider.
// Depends on ihrs_pkg, ihrs_ram and ihrs_div.
`default_nettype none
module ihrs_dp #(
  parameter int CHANNELS = 256,
  parameter int NBINS    = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ihrs_pkg::ihrs_cmd_t cmd,
  input  wire                 clearing,
  input  wire  [7:0]          channel,
  input  wire  [31:0]         sample,
  input  wire  [31:0]         range_low,
  input  wire  [31:0]         range_high,
  output ihrs_pkg::ihrs_sts_t sts,
  output logic [230:0]        result
);
  import ihrs_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BW = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int HD = CHANNELS * NBINS;
  localparam int HW = $clog2(HD) > 0 ? $clog2(HD) : 1;
  localparam int CD = 1 << CW;
  localparam int HDP = 1 << HW;

  logic [7:0]  ch;
  logic signed [31:0] v;
  logic        ch_ok;
  logic [1:0]  place;
  logic [BW-1:0] bin;
  logic [HW-1:0] clr_cnt;
  logic        clr_done;

  logic        div_start;
  logic        div_busy, div_done;
  logic [63:0] div_a, div_b, div_q;

  ihrs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .quotient(div_q), .busy(div_busy), .done(div_done)
  );

  assign clr_done = clearing && (clr_cnt == HW'(HDP - 1));
  assign sts = '{div_busy: div_busy, div_done: div_done, clear_done: clr_done};

  // Stores: rows written during the clearing sweep and at finish
  logic            we_c, we_h;
  logic [CW-1:0]   a_c;
  logic [HW-1:0]   a_h;
  logic [31:0]     r_bc, r_below, r_above, r_cnt, r_min, r_max, r_mean;
  logic [63:0]     r_dev;
  logic [31:0]     w_bc, w_below, w_above, w_cnt, w_min, w_max, w_mean;
  logic [63:0]     w_dev;

  ihrs_ram #(.WIDTH(32), .DEPTH(HDP)) u_bins  (.clk(clk), .we(we_h), .addr(a_h),
    .wdata(w_bc), .rdata(r_bc));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_below (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_below), .rdata(r_below));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_above (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_above), .rdata(r_above));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_cnt   (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_cnt), .rdata(r_cnt));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_min   (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_min), .rdata(r_min));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_max   (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_max), .rdata(r_max));
  ihrs_ram #(.WIDTH(32), .DEPTH(CD)) u_mean  (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_mean), .rdata(r_mean));
  ihrs_ram #(.WIDTH(64), .DEPTH(CD)) u_dev   (.clk(clk), .we(we_c), .addr(a_c),
    .wdata(w_dev), .rdata(r_dev));

  // Captured store values
  logic [31:0] c_bc, c_below, c_above, c_cnt, c_mean;
  logic signed [31:0] c_min, c_max;
  logic [63:0] c_dev;
  logic        rd_addr;
  logic        rd_pend;

  logic signed [32:0] vm_lo, hi_m_lo;
  logic [32:0] span;
  logic [31:0] n_new;
  logic signed [32:0] delta;
  logic [32:0] dmag;

  assign vm_lo   = {sample[31], sample} - {range_low[31], range_low};
  assign hi_m_lo = {range_high[31], range_high} - {range_low[31], range_low};
  assign span    = hi_m_lo;
  assign n_new   = (c_cnt == 32'hffffffff) ? c_cnt : c_cnt + 32'd1;
  assign delta   = {v[31], v} - {c_mean[31], c_mean};
  assign dmag    = delta[32] ? 33'd0 - delta : delta;

  always_comb begin
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    if (cmd.load) begin
      div_start = 1'b1;
      div_a = 64'(vm_lo[32:0]) * 64'(NBINS);
      div_b = {31'd0, span};
      if (span == 33'd0) div_b = 64'd1;
      if (NBINS == 1) div_a = '0;
    end else if (cmd.mean_go) begin
      div_start = 1'b1;
      div_a = {31'd0, dmag};
      div_b = {32'd0, n_new};
    end
  end

  // Bin from quotient with clamp
  logic [BW-1:0] bin_q;
  always_comb begin
    if (div_q > 64'(NBINS - 1)) bin_q = BW'(NBINS - 1);
    else bin_q = div_q[BW-1:0];
  end

  // Mean and deviation arithmetic, evaluated in finish
  logic signed [33:0] q_s, mean_w;
  logic signed [31:0] mean_n;
  logic signed [32:0] dev2;
  logic [32:0] d2mag;
  logic [65:0] prod;
  logic [63:0] acc;
  logic [31:0] hits;
  logic signed [31:0] min_n, max_n;
  logic [32:0] q_lat;

  assign q_s = delta[32] ? -$signed({1'b0, q_lat}) : $signed({1'b0, q_lat});
  assign mean_w = $signed({{2{c_mean[31]}}, c_mean}) + q_s;
  always_comb begin
    if (mean_w > 34'sd2147483647) mean_n = 32'sh7fffffff;
    else if (mean_w < -34'sd2147483648) mean_n = 32'sh80000000;
    else mean_n = mean_w[31:0];
  end
  assign dev2  = {v[31], v} - {mean_n[31], mean_n};
  assign d2mag = dev2[32] ? 33'd0 - dev2 : dev2;
  assign prod  = dmag * d2mag;

  always_comb begin
    if (delta == 0 || dev2 == 0 || (delta[32] == dev2[32])) begin
      if (prod > 66'(64'h7fffffffffffffff - c_dev)) acc = 64'h7fffffffffffffff;
      else acc = c_dev + prod[63:0];
    end else begin
      if (prod > 66'(c_dev)) acc = '0;
      else acc = c_dev - prod[63:0];
    end
    case (place)
      PLACE_BELOW: hits = (c_below == 32'hffffffff) ? c_below : c_below + 32'd1;
      PLACE_ABOVE: hits = (c_above == 32'hffffffff) ? c_above : c_above + 32'd1;
      default:     hits = (c_bc == 32'hffffffff) ? c_bc : c_bc + 32'd1;
    endcase
    if (c_cnt == 32'd0) begin
      min_n = v;
      max_n = v;
    end else begin
      min_n = (v < c_min) ? v : c_min;
      max_n = (v > c_max) ? v : c_max;
    end
  end

  always_comb begin
    we_c = clearing || (cmd.finish && ch_ok);
    we_h = clearing || (cmd.finish && ch_ok && place == PLACE_BIN);
    a_c  = clearing ? clr_cnt[CW-1:0] : CW'(ch);
    a_h  = clearing ? clr_cnt : HW'(32'(ch) * 32'(NBINS) + 32'(bin));
    if (clearing) begin
      w_bc = '0; w_below = '0; w_above = '0; w_cnt = '0;
      w_min = '0; w_max = '0; w_mean = '0; w_dev = '0;
    end else begin
      w_bc    = hits;
      w_below = (place == PLACE_BELOW) ? hits : c_below;
      w_above = (place == PLACE_ABOVE) ? hits : c_above;
      w_cnt   = n_new;
      w_min   = min_n;
      w_max   = max_n;
      w_mean  = mean_n;
      w_dev   = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      rd_addr <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      rd_addr <= cmd.bin_done;
      rd_pend <= rd_addr;
    end
    if (cmd.load) begin
      ch <= channel;
      v  <= sample;
      ch_ok <= (32'(channel) < 32'(CHANNELS));
      if ($signed(sample) < $signed(range_low)) place <= PLACE_BELOW;
      else if ($signed(sample) > $signed(range_high)) place <= PLACE_ABOVE;
      else place <= PLACE_BIN;
    end
    if (cmd.bin_done) begin
      bin <= (place == PLACE_BIN) ? bin_q : '0;
    end
    if (rd_pend) begin
      c_bc <= r_bc; c_below <= r_below; c_above <= r_above; c_cnt <= r_cnt;
      c_min <= r_min; c_max <= r_max; c_mean <= r_mean; c_dev <= r_dev;
    end
    if (div_done && !cmd.bin_done) begin
      q_lat <= div_q[32:0];
    end
    if (cmd.finish) begin
      if (ch_ok) begin
        result <= {acc[62:0], mean_n, max_n, min_n, n_new, hits,
                   6'(bin), place};
      end else begin
        result <= '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/indexed_histogram_running_stats_unit.sv
// Indexed histogram and per-channel Welford running statistics, top level.
// Depends on ihrs_pkg, ihrs_ctrl, ihrs_dp.
// One item at a time: each item takes two passes of the one-bit-per-cycle
// 64-step divider (bin index, then mean step), a store read through the
// ADDR, FETCH and READ states, and a write-back in FIN before idle.
// A result held by m_tready low stalls the next item. After reset a clearing
// pass over CHANNELS*NBINS addresses, rounded up to a power of two (16384 by
// default), zeroes all stores; no item is taken during it.
`default_nettype none
module indexed_histogram_running_stats_unit #(
  parameter int CHANNELS = 256,
  parameter int NBINS    = 64
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [39:0]  s_tdata,   // channel[7:0], sample[39:8]
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [231:0] m_tdata,   // placement[1:0], bin_number[7:2], hit_count[39:8],
                                  // sample_total[71:40], least_seen[103:72],
                                  // greatest_seen[135:104], running_mean[167:136],
                                  // squared_deviation_sum[230:168], pad[231]
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ihrs_pkg::*;

  ihrs_cmd_t   cmd;
  ihrs_sts_t   sts;
  logic        clearing;
  logic [31:0] range_low, range_high;
  logic [230:0] result;
  logic        in_fire;

  assign pready  = 1'b1;
  assign in_fire = s_tvalid && s_tready;
  assign prdata  = (paddr == REG_RANGE_HIGH) ? range_high :
                   (paddr == REG_RANGE_LOW) ? range_low : 32'd0;
  assign m_tdata = {1'b0, result};

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= 32'd0;
      range_high <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_RANGE_LOW) range_low <= pwdata;
      if (paddr == REG_RANGE_HIGH) range_high <= pwdata;
    end
  end

  ihrs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_taken(m_tvalid && m_tready),
    .sts(sts), .cmd(cmd), .in_ready(s_tready), .out_valid(m_tvalid),
    .clearing(clearing)
  );

  ihrs_dp #(.CHANNELS(CHANNELS), .NBINS(NBINS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .clearing(clearing),
    .channel(s_tdata[7:0]), .sample(s_tdata[39:8]),
    .range_low(range_low), .range_high(range_high), .sts(sts), .result(result)
  );
endmodule
`default_nettype wire
